### rtl/fraf_pkg.sv
// Package for the recent-address filter: widths, register map, cell types and phase codes.
// Depends on nothing; every other file of the block imports it.
package fraf_pkg;

    localparam int ADDR_W  = 64;
    localparam int DEPTH_W = 7;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [DEPTH_W-1:0] ACTIVE_DEPTH_RESET = 7'd64;
    localparam logic CFG_IDX_ACTIVE_DEPTH = 1'b0;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_cell_state;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DEC  = 3'b100
    } t_phase;

endpackage

### rtl/fraf_in_if.sv
// Input channel of the recent-address filter: valid, ready and the address.
// Depends on fraf_pkg.
interface fraf_in_if;
    import fraf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;

    modport source(output valid, output addr, input ready);
    modport sink(input valid, input addr, output ready);
endinterface

### rtl/fraf_out_if.sv
// Output channel of the recent-address filter: valid, ready and the passed address.
// Depends on fraf_pkg.
interface fraf_out_if;
    import fraf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] new_addr;

    modport source(output valid, output new_addr, input ready);
    modport sink(input valid, input new_addr, output ready);
endinterface

### rtl/fraf_cell.sv
// One cell of the filter chain: holds one address and its valid bit, compares it against
// the search key and takes its neighbor's contents on an insert. Depends on fraf_pkg.
module fraf_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fraf_pkg::t_cell_ctrl        i_ctrl,
    input  logic                        i_keep,
    input  logic [fraf_pkg::ADDR_W-1:0] i_key,
    input  fraf_pkg::t_cell_state       i_prev,
    output fraf_pkg::t_cell_state       o_state,
    output logic                        o_hit
);
    import fraf_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic              r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev.valid & i_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_addr <= i_prev.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= r_valid && (r_addr == i_key);
        end
    end

    assign o_state.valid = r_valid;
    assign o_state.addr  = r_addr;
    assign o_hit         = r_hit;

endmodule

### rtl/fifo_recent_address_filter.sv
// Recent-address filter: a chain of cells holds the newest addresses, newest in the first cell.
// An accepted address passes through capture, per-cell compare, then decide and insert.
// A new address is taken only in the idle phase, after the current one has been decided.
// A result appears in the output register on the cycle after the decision.
// Synchronous active-low reset empties the chain and sets the active depth to 64.
module fifo_recent_address_filter #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fraf_in_if.sink                      i_in,
    fraf_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fraf_pkg::PADDR_W-1:0] paddr,
    input  logic [fraf_pkg::DATA_W-1:0]  pwdata,
    output logic [fraf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import fraf_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [ADDR_W-1:0]  r_key;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;

    logic [31:0]        eff_depth;
    logic               cfg_wr;
    logic               hit_any;
    logic               insert;
    t_cell_ctrl         ctrl;
    t_cell_state        cell_st [DEPTH];
    logic [DEPTH-1:0]   hits;
    logic [DEPTH-1:0]   valid_vec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == CFG_IDX_ACTIVE_DEPTH);
    assign prdata = (paddr[2] == CFG_IDX_ACTIVE_DEPTH)
                    ? {{(DATA_W-DEPTH_W){1'b0}}, r_depth} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= ACTIVE_DEPTH_RESET;
        end else if (cfg_wr) begin
            r_depth <= pwdata[DEPTH_W-1:0];
        end
    end

    always_comb begin
        if (r_depth == '0) begin
            eff_depth = 32'd1;
        end else if (32'(r_depth) > 32'(DEPTH)) begin
            eff_depth = 32'(DEPTH);
        end else begin
            eff_depth = 32'(r_depth);
        end
    end

    assign hit_any = |hits;
    assign insert  = (r_phase == S_DEC) && !hit_any && (!r_out_valid || o_out.ready);
    assign ctrl.shift = insert;
    assign ctrl.clear = cfg_wr;
    assign i_in.ready = (r_phase == S_IDLE);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_phase = S_CMP;
                end
            end
            S_CMP: begin
                n_phase = S_DEC;
            end
            S_DEC: begin
                if (hit_any || insert) begin
                    n_phase = S_IDLE;
                end
            end
            default: begin
                n_phase = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key <= i_in.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (insert) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (insert) begin
            r_out_addr <= r_key;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.new_addr = r_out_addr;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_state prev;
        logic        keep;

        assign keep = (32'(gi) < eff_depth);

        if (gi == 0) begin : g_head
            assign prev.valid = 1'b1;
            assign prev.addr  = r_key;
        end else begin : g_body
            assign prev = cell_st[gi-1];
        end

        fraf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_keep  (keep),
            .i_key   (r_key),
            .i_prev  (prev),
            .o_state (cell_st[gi]),
            .o_hit   (hits[gi])
        );

        assign valid_vec[gi] = cell_st[gi].valid;
    end

`ifndef ASSERT_OFF
    a_insert_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        insert |=> (r_out_valid && (r_out_addr == $past(r_key))))
        else $error("inserted address did not reach the output register");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'($countones(valid_vec)) <= eff_depth))
        else $error("more held entries than the active depth");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (valid_vec == '0))
        else $error("depth write did not empty the filter");

    a_hit_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == S_DEC) && hit_any) |=> (valid_vec == $past(valid_vec)))
        else $error("a matching transaction changed the held entries");
`endif

endmodule

### verif/fraf_checker.sv
// Scoreboard for the recent-address filter: watches both channels and the register port,
// predicts each passed address and compares it with what the block delivers.
// Depends on fraf_pkg, fraf_in_if and fraf_out_if.
`timescale 1ns / 1ps

module fraf_checker #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fraf_in_if                           i_in_ch,
    fraf_out_if                          i_out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fraf_pkg::PADDR_W-1:0] paddr,
    input  logic [fraf_pkg::DATA_W-1:0]  pwdata,
    input  logic [fraf_pkg::DATA_W-1:0]  prdata,
    input  logic                         pready,
    output int                           o_mismatch_count,
    output int                           o_pending_count,
    output int                           o_result_count
);
    import fraf_pkg::*;

    localparam int PRINT_CAP = 200;

    logic [ADDR_W-1:0]  held_addr [DEPTH];
    logic               held_valid [DEPTH];
    int unsigned        oldest_slot;
    int unsigned        held_total;
    logic [DEPTH_W-1:0] depth_reg;
    logic [ADDR_W-1:0]  passed_q [$];

    task automatic report_mismatch(input string what);
        if (o_mismatch_count < PRINT_CAP) begin
            $display("fraf_checker: %0t: %s", $realtime, what);
        end
        o_mismatch_count++;
    endtask

    function automatic int unsigned depth_limit();
        if (depth_reg == '0) begin
            return 1;
        end
        if (int'(depth_reg) > DEPTH) begin
            return DEPTH;
        end
        return int'(depth_reg);
    endfunction

    function automatic void empty_filter();
        for (int i = 0; i < DEPTH; i++) begin
            held_valid[i] = 1'b0;
            held_addr[i]  = '0;
        end
        oldest_slot = 0;
        held_total  = 0;
    endfunction

    // Returns 1 when the address is new and therefore passed through.
    function automatic bit filter_address(input logic [ADDR_W-1:0] a);
        int unsigned lim;
        int unsigned slot;
        lim = depth_limit();
        for (int i = 0; i < DEPTH; i++) begin
            if (held_valid[i] && held_addr[i] == a) begin
                return 1'b0;
            end
        end
        if (held_total >= lim && held_total > 0) begin
            held_valid[oldest_slot] = 1'b0;
            oldest_slot = (oldest_slot + 1) % DEPTH;
            held_total--;
        end
        slot = (oldest_slot + held_total) % DEPTH;
        held_addr[slot]  = a;
        held_valid[slot] = 1'b1;
        held_total++;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_reg = ACTIVE_DEPTH_RESET;
            empty_filter();
            passed_q.delete();
        end else begin
            if (psel && penable && pready && (paddr >> 2) == PADDR_W'(CFG_IDX_ACTIVE_DEPTH)) begin
                if (pwrite) begin
                    depth_reg = pwdata[DEPTH_W-1:0];
                    empty_filter();
                end else if (prdata !== DATA_W'(depth_reg)) begin
                    report_mismatch($sformatf("active_depth read %h, expected %h",
                                              prdata, DATA_W'(depth_reg)));
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (filter_address(i_in_ch.addr)) begin
                    passed_q.push_back(i_in_ch.addr);
                end
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                o_result_count++;
                if (passed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction new_addr %h",
                                              i_out_ch.new_addr));
                end else begin
                    if (i_out_ch.new_addr !== passed_q[0]) begin
                        report_mismatch($sformatf("new_addr %h, expected %h",
                                                  i_out_ch.new_addr, passed_q[0]));
                    end
                    void'(passed_q.pop_front());
                end
            end
        end
        o_pending_count = passed_q.size();
    end

endmodule

### verif/tb_top.sv
// Top of the recent-address filter testbench: clock, reset, register writes and address stimulus.
// Prediction and comparison live in fraf_checker; depends on fraf_pkg and both channel interfaces.
`timescale 1ns / 1ps

module tb_top;
    import fraf_pkg::*;

    localparam int DEPTH          = 64;
    localparam int IDLE_PCT       = 35;
    localparam int DRAIN_CYCLES   = 12;
    localparam int UNUSED_REG_IDX = 1;
    localparam int NUM_PHASES     = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  mismatch_count;
    int                  pending_count;
    int                  result_count;
    int                  sent_count;
    int                  cfg_count;
    bit                  no_idle;
    logic [ADDR_W-1:0]   addr_pool [$];
    logic [DATA_W-1:0]   phase_depth [NUM_PHASES] = '{
        32'd64, 32'd1, 32'd127, 32'hFFFF_FF83, 32'd17,
        32'd65, 32'd63, 32'd8, 32'd2, 32'd32
    };

    fraf_in_if  in_ch();
    fraf_out_if out_ch();

    fifo_recent_address_filter #(.DEPTH(DEPTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    fraf_checker #(.DEPTH(DEPTH)) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_ch         (in_ch),
        .i_out_ch        (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count),
        .o_result_count  (result_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_addr(input logic [ADDR_W-1:0] a);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.addr  <= a;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Stops the sender and waits until every passed address has come out.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input int idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_depth(input logic [DATA_W-1:0] value);
        drain();
        apb_access(1'b1, int'(CFG_IDX_ACTIVE_DEPTH), value);
        apb_access(1'b0, int'(CFG_IDX_ACTIVE_DEPTH), '0);
        cfg_count++;
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] value, input bit pause_midway);
        int          eff;
        int          n_items;
        int          pool_size;
        int          pick;
        logic [63:0] a;
        eff = int'(value & 32'h7F);
        if (eff == 0) begin
            eff = 1;
        end
        if (eff > DEPTH) begin
            eff = DEPTH;
        end
        n_items   = 24 + eff;
        pool_size = eff + $urandom_range(1, eff / 2 + 2);
        addr_pool.delete();
        for (int i = 0; i < pool_size; i++) begin
            addr_pool.push_back({$urandom, $urandom});
        end
        set_depth(value);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            a = addr_pool[$urandom_range(pool_size - 1)];
            if (pick >= 85) begin
                a = {$urandom, $urandom};
            end else if (pick >= 70) begin
                a = a ^ (64'd1 << $urandom_range(63));
            end
            send_addr(a);
            if (pause_midway && i == n_items / 2) begin
                drain();
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.addr   = '0;
        out_ch.ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_idle      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset depth: zero, all ones, single-bit and alternating patterns; zero and all ones are sent twice or more.
        send_addr(64'h0);
        send_addr(64'h0);
        send_addr(64'hFFFF_FFFF_FFFF_FFFF);
        send_addr(64'hFFFF_FFFF_FFFF_FFFF);
        send_addr(64'h1);
        send_addr(64'h8000_0000_0000_0000);
        send_addr(64'h5555_5555_5555_5555);
        send_addr(64'hAAAA_AAAA_AAAA_AAAA);
        send_addr(64'h0);

        // A write outside the register map must leave the held addresses alone.
        drain();
        apb_access(1'b1, UNUSED_REG_IDX, 32'h0000_0001);
        send_addr(64'h0);
        send_addr(64'h8000_0000_0000_0000);

        // Depth two: the oldest entry is evicted, a hit keeps the order.
        set_depth(32'd2);
        send_addr(64'h1234_5678_9ABC_DEF0);
        send_addr(64'h0FED_CBA9_8765_4321);
        send_addr(64'h1234_5678_9ABC_DEF0);
        send_addr(64'h0000_0000_DEAD_BEEF);
        send_addr(64'h1234_5678_9ABC_DEF0);
        send_addr(64'h0FED_CBA9_8765_4321);

        // Depth zero behaves as depth one.
        set_depth(32'd0);
        send_addr(64'h0000_0000_0000_0042);
        send_addr(64'h0000_0000_0000_0042);
        send_addr(64'h0000_0000_0000_0043);
        send_addr(64'h0000_0000_0000_0042);

        for (int p = 0; p < NUM_PHASES; p++) begin
            no_idle = (p == 3);
            if (p % 2 == 1) begin
                phase_depth[p] = phase_depth[p] | ($urandom & 32'hFFFF_FF80);
            end
            run_phase(phase_depth[p], p == 5);
        end
        no_idle = 1'b0;

        drain();
        $display("tb_top: %0d addresses sent over %0d depth settings, %0d new addresses seen",
                 sent_count, cfg_count, result_count);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/fraf_pkg.sv
rtl/fraf_in_if.sv
rtl/fraf_out_if.sv
rtl/fraf_cell.sv
rtl/fifo_recent_address_filter.sv
verif/fraf_checker.sv
verif/tb_top.sv
